// File: hdl/lac_pkg.sv
// Shared types, register map and constant tables for the cross-channel normalizer.
package lac_pkg;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd0;
    localparam logic [2:0] REG_PIXEL_COUNT     = 3'd1;
    localparam logic [2:0] REG_WINDOW_SIZE     = 3'd2;
    localparam logic [2:0] REG_ALPHA_OVER_SIZE = 3'd3;
    localparam logic [2:0] REG_BETA_EXPONENT   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic rd1;
        logic upd;
        logic rd2;
        logic fetch;
        logic uload;
        logic norm_step;
        logic log_init;
        logic log_step;
        logic emul;
        logic pow_step;
        logic mag;
        logic load_out;
        logic clr_step;
    } lac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic emit;
        logic norm_done;
        logic iter_done;
        logic out_free;
    } lac_sts_t;

    typedef logic [31:0] lac_exp_tab_t [0:15];

    function automatic logic [63:0] lac_isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bit_w;
        r     = 64'd0;
        rem   = v;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + bit_w)
            begin
                rem = rem - (r + bit_w);
                r   = (r >> 1) + bit_w;
            end
            else
            begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    // Entry j holds 2^-(2^-(j+1)) in Q1.31, built by repeated square roots.
    function automatic lac_exp_tab_t lac_make_exp_tab();
        lac_exp_tab_t tab;
        logic [63:0]  t;
        t      = lac_isqrt64(64'd1 << 61);
        tab[0] = t[31:0];
        for (int j = 1; j < 16; j++)
        begin
            t      = lac_isqrt64({t[32:0], 31'd0});
            tab[j] = t[31:0];
        end
        return tab;
    endfunction

    localparam lac_exp_tab_t EXP_TAB = lac_make_exp_tab();

endpackage

// File: hdl/lrn_across_channels.sv
// Top level of the cross-channel local response normalizer with its register port.
//
// Activations enter one beat at a time on the input channel (in_valid/in_ready),
// channel-major: every pixel of channel 0, then channel 1, and so on. A command
// of 1 is a flush beat; after channel_count real channels the source sends
// floor(window_size/2) flush channels so the last channels drain out.
// Each beat updates the pixel's running sum of squares and, once the window
// has filled past the center, yields one normalized value on the output
// channel (out_valid/out_ready), tagged with its channel, pixel and a last flag.
// The block handles one beat at a time. A beat that yields nothing passes
// through the read and update states before the next acceptance. A beat
// that yields a result also runs the log2 and exp2 units: the leading-one
// search of the log2 unit shifts one bit per cycle, the log2 fraction takes
// 16 squaring steps and the exp2 unit 16 multiply steps, each a 32x32 multiply.
// After reset the square-sum memory is swept to zero, one pixel per cycle over
// all MAX_PIXELS entries, and no beat is accepted until that pass ends; register
// writes are taken throughout. The result sits in an output register; while
// the receiver stalls, the next beat is still accepted and worked on up to
// the point where its own result would overwrite the waiting one.
module lrn_across_channels #(
    parameter int MAX_PIXELS   = 4096,
    parameter int MAX_WINDOW   = 9,
    parameter int MAX_CHANNELS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [15:0] sample_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] norm_value,
    output logic [9:0]         channel_index,
    output logic [11:0]        pixel_index,
    output logic               last
);

    logic [10:0] channel_count_reg;
    logic [12:0] pixel_count_reg;
    logic [3:0]  window_size_reg;
    logic [31:0] alpha_over_size_reg;
    logic [15:0] beta_exponent_reg;
    logic        wr_en;
    logic [2:0]  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    // Configuration registers; writes to unmapped addresses are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg   <= 11'd64;
            pixel_count_reg     <= 13'd1024;
            window_size_reg     <= 4'd5;
            alpha_over_size_reg <= 32'd85899;
            beta_exponent_reg   <= 16'd3072;
        end
        else if (wr_en)
        begin
            case (reg_index)
                lac_pkg::REG_CHANNEL_COUNT:   channel_count_reg   <= pwdata[10:0];
                lac_pkg::REG_PIXEL_COUNT:     pixel_count_reg     <= pwdata[12:0];
                lac_pkg::REG_WINDOW_SIZE:     window_size_reg     <= pwdata[3:0];
                lac_pkg::REG_ALPHA_OVER_SIZE: alpha_over_size_reg <= pwdata;
                lac_pkg::REG_BETA_EXPONENT:   beta_exponent_reg   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            lac_pkg::REG_CHANNEL_COUNT:   prdata = {21'd0, channel_count_reg};
            lac_pkg::REG_PIXEL_COUNT:     prdata = {19'd0, pixel_count_reg};
            lac_pkg::REG_WINDOW_SIZE:     prdata = {28'd0, window_size_reg};
            lac_pkg::REG_ALPHA_OVER_SIZE: prdata = alpha_over_size_reg;
            lac_pkg::REG_BETA_EXPONENT:   prdata = {16'd0, beta_exponent_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    lac_pkg::lac_cmd_t cmd;
    lac_pkg::lac_sts_t sts;

    lac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lac_dp #(
        .MAX_PIXELS   (MAX_PIXELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .command         (command),
        .sample_value    (sample_value),
        .channel_count   (channel_count_reg),
        .pixel_count     (pixel_count_reg),
        .window_size     (window_size_reg),
        .alpha_over_size (alpha_over_size_reg),
        .beta_exponent   (beta_exponent_reg),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .norm_value      (norm_value),
        .channel_index   (channel_index),
        .pixel_index     (pixel_index),
        .last            (last)
    );

endmodule

// File: hdl/lac_ram.sv
// Generic simple dual-port RAM with registered read data.
module lac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lac_ctrl.sv
// Controller state machine sequencing one beat through the datapath.
module lac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lac_pkg::lac_sts_t sts,
    output lac_pkg::lac_cmd_t cmd
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_READ  = 14'b00000000000100,
        S_UPD   = 14'b00000000001000,
        S_READ2 = 14'b00000000010000,
        S_FETCH = 14'b00000000100000,
        S_ULOAD = 14'b00000001000000,
        S_NORM  = 14'b00000010000000,
        S_LOG   = 14'b00000100000000,
        S_EMUL  = 14'b00001000000000,
        S_POW   = 14'b00010000000000,
        S_MAG   = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd1    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = sts.emit ? S_READ2 : S_IDLE;
            end
            S_READ2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_ULOAD;
            end
            S_ULOAD:
            begin
                cmd.uload  = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    cmd.log_init = 1'b1;
                    state_next   = S_LOG;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                if (sts.iter_done)
                begin
                    state_next = S_EMUL;
                end
            end
            S_EMUL:
            begin
                cmd.emul   = 1'b1;
                state_next = S_POW;
            end
            S_POW:
            begin
                cmd.pow_step = 1'b1;
                if (sts.iter_done)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lac_dp.sv
// Datapath: square-sum and value memories, log2/exp2 units and the output register.
module lac_dp #(
    parameter int MAX_PIXELS   = 4096,
    parameter int MAX_WINDOW   = 9,
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lac_pkg::lac_cmd_t   cmd,
    output lac_pkg::lac_sts_t   sts,
    input  logic                command,
    input  logic signed [15:0]  sample_value,
    input  logic [10:0]         channel_count,
    input  logic [12:0]         pixel_count,
    input  logic [3:0]          window_size,
    input  logic [31:0]         alpha_over_size,
    input  logic [15:0]         beta_exponent,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [15:0]  norm_value,
    output logic [9:0]          channel_index,
    output logic [11:0]         pixel_index,
    output logic                last
);

    localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW  = $clog2(MAX_CHANNELS + MAX_WINDOW);
    localparam int RD  = MAX_PIXELS * MAX_WINDOW;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;

    // Clamped configuration.
    logic [CW-1:0] cc_c;
    logic [CW-1:0] total;
    logic [PW:0]   pc_c;
    logic [3:0]    ws_c;
    logic [3:0]    h;

    always_comb
    begin
        if (channel_count == 11'd0)
            cc_c = CW'(1);
        else if (32'(channel_count) > MAX_CHANNELS)
            cc_c = CW'(MAX_CHANNELS);
        else
            cc_c = CW'(channel_count);
        if (pixel_count == 13'd0)
            pc_c = (PW+1)'(1);
        else if (32'(pixel_count) > MAX_PIXELS)
            pc_c = (PW+1)'(MAX_PIXELS);
        else
            pc_c = (PW+1)'(pixel_count);
        if (window_size == 4'd0)
            ws_c = 4'd1;
        else if (window_size > 4'(MAX_WINDOW))
            ws_c = 4'(MAX_WINDOW);
        else
            ws_c = window_size;
        h     = ws_c >> 1;
        total = cc_c + CW'(h);
    end

    // Position and item registers.
    logic [CW-1:0]       c_reg;
    logic [PW-1:0]       p_reg;
    logic [SW-1:0]       slot_reg;
    logic [PW-1:0]       clr_reg;
    logic                out_valid_reg;
    logic signed [15:0]  x_reg;
    logic [31:0]         sq_reg;
    logic [SW-1:0]       oslot_reg;
    logic [CW-1:0]       oc_reg;
    logic [PW-1:0]       op_reg;
    logic                olast_reg;
    logic [35:0]         sum_reg;
    logic signed [15:0]  v_reg;
    logic [63:0]         prod_reg;
    logic [36:0]         w_reg;
    logic [5:0]          k_reg;
    logic [31:0]         m_reg;
    logic [20:0]         l_reg;
    logic [3:0]          j_reg;
    logic [36:0]         e_reg;
    logic [31:0]         g_reg;
    logic [47:0]         mag_reg;
    logic signed [15:0]  norm_reg;
    logic [9:0]          ch_reg;
    logic [11:0]         px_reg;
    logic                last_reg;

    // Memories.
    logic [35:0]         sums_rdata;
    logic [15:0]         ring_rdata;
    logic                sums_we;
    logic [PW-1:0]       sums_waddr;
    logic [35:0]         sums_wdata;
    logic [RAW-1:0]      ring_waddr;
    logic [RAW-1:0]      ring_raddr;
    logic [35:0]         sum_new;

    assign sums_we    = cmd.clr_step | cmd.upd;
    assign sums_waddr = cmd.clr_step ? clr_reg : p_reg;
    assign sums_wdata = cmd.clr_step ? 36'd0 : sum_new;
    assign ring_waddr = RAW'(32'(slot_reg) * MAX_PIXELS + 32'(p_reg));
    assign ring_raddr = cmd.rd2 ? RAW'(32'(oslot_reg) * MAX_PIXELS + 32'(op_reg))
                                : ring_waddr;

    lac_ram #(.WIDTH(36), .DEPTH(MAX_PIXELS)) u_sums (
        .clk   (clk),
        .we    (sums_we),
        .waddr (sums_waddr),
        .wdata (sums_wdata),
        .raddr (p_reg),
        .rdata (sums_rdata)
    );

    lac_ram #(.WIDTH(16), .DEPTH(RD)) u_ring (
        .clk   (clk),
        .we    (cmd.upd),
        .waddr (ring_waddr),
        .wdata (x_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // Input value after flush and past-end substitution.
    logic signed [15:0] x_in;
    assign x_in = (!command && (32'(c_reg) < 32'(cc_c))) ? sample_value : 16'sd0;

    logic signed [31:0] sq_s;
    assign sq_s = x_reg * x_reg;

    // Square sum update.
    logic signed [15:0] old_v;
    logic signed [31:0] osq_s;
    logic [36:0]        base;
    logic [35:0]        sat;
    assign old_v = ring_rdata;
    assign osq_s = old_v * old_v;

    always_comb
    begin
        if (c_reg == '0)
            base = {5'd0, sq_reg};
        else
            base = {1'b0, sums_rdata} + {5'd0, sq_reg};
        sat = base[36] ? {36{1'b1}} : base[35:0];
        if (32'(c_reg) >= 32'(ws_c))
            sum_new = (sat > {4'd0, osq_s}) ? sat - {4'd0, osq_s} : 36'd0;
        else
            sum_new = sat;
    end

    logic emit;
    logic last_n;
    logic p_wrap;
    logic c_wrap;
    logic [4:0] oslot_n;
    assign emit    = 32'(c_reg) >= 32'(h);
    assign p_wrap  = (32'(p_reg) + 32'd1) >= 32'(pc_c);
    assign c_wrap  = (32'(c_reg) + 32'd1) >= 32'(total);
    assign last_n  = p_wrap && c_wrap;
    assign oslot_n = (5'(slot_reg) >= 5'(h)) ? 5'(slot_reg) - 5'(h)
                                             : 5'(slot_reg) + 5'(ws_c) - 5'(h);

    // Arithmetic units.
    logic [35:0] ash;
    logic [63:0] msq;
    logic [32:0] q;
    logic [63:0] gp;
    logic [15:0] f;
    logic [16:0] av;
    logic [8:0]  n;
    logic [17:0] t;
    logic [17:0] r;
    logic signed [15:0] res;

    assign ash = alpha_over_size * sum_reg[35:32];
    assign msq = m_reg * m_reg;
    assign q   = msq[63:31];
    assign gp  = g_reg * lac_pkg::EXP_TAB[j_reg];
    assign f   = e_reg[27:12];
    assign av  = v_reg[15] ? (17'd0 - {v_reg[15], v_reg}) : {1'b0, v_reg};
    assign n   = e_reg[36:28];

    always_comb
    begin
        t = 18'(mag_reg >> 30) >> n[4:0];
        r = (n >= 9'd32) ? 18'd0 : ((t + 18'd1) >> 1);
        if (v_reg[15])
            res = (r > 18'd32768) ? -16'sd32768 : 16'(18'd0 - r);
        else
            res = (r > 18'd32767) ? 16'sd32767 : 16'(r);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg         <= '0;
            p_reg         <= '0;
            slot_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + PW'(1);
            if (cmd.upd)
            begin
                if (p_wrap)
                begin
                    p_reg <= '0;
                    if (c_wrap)
                    begin
                        c_reg    <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        c_reg    <= c_reg + CW'(1);
                        slot_reg <= (32'(slot_reg) + 32'd1 >= 32'(ws_c)) ? '0
                                                                         : slot_reg + SW'(1);
                    end
                end
                else
                begin
                    p_reg <= p_reg + PW'(1);
                end
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            x_reg <= x_in;
        if (cmd.rd1)
            sq_reg <= sq_s;
        if (cmd.upd)
        begin
            sum_reg   <= sum_new;
            oslot_reg <= SW'(oslot_n);
            oc_reg    <= c_reg - CW'(h);
            op_reg    <= p_reg;
            olast_reg <= last_n;
        end
        if (cmd.fetch)
        begin
            v_reg    <= ring_rdata;
            prod_reg <= alpha_over_size * sum_reg[31:0];
        end
        if (cmd.uload)
        begin
            w_reg <= 37'd65536 + 37'(ash) + 37'(prod_reg[63:32]);
            k_reg <= 6'd36;
        end
        if (cmd.norm_step)
        begin
            w_reg <= w_reg << 1;
            k_reg <= k_reg - 6'd1;
        end
        if (cmd.log_init)
        begin
            m_reg <= w_reg[36:5];
            l_reg <= {5'(k_reg - 6'd16), 16'd0};
            j_reg <= 4'd0;
        end
        if (cmd.log_step)
        begin
            if (q[32])
            begin
                m_reg                 <= q[32:1];
                l_reg[4'd15 - j_reg]  <= 1'b1;
            end
            else
            begin
                m_reg <= q[31:0];
            end
            j_reg <= j_reg + 4'd1;
        end
        if (cmd.emul)
        begin
            e_reg <= beta_exponent * l_reg;
            g_reg <= 32'h8000_0000;
            j_reg <= 4'd0;
        end
        if (cmd.pow_step)
        begin
            if (f[4'd15 - j_reg])
                g_reg <= gp[62:31];
            j_reg <= j_reg + 4'd1;
        end
        if (cmd.mag)
            mag_reg <= 48'(av) * 48'(g_reg);
        if (cmd.load_out)
        begin
            norm_reg <= res;
            ch_reg   <= 10'(32'(oc_reg));
            px_reg   <= 12'(32'(op_reg));
            last_reg <= olast_reg;
        end
    end

    assign sts.clr_done  = (clr_reg == PW'(MAX_PIXELS - 1));
    assign sts.emit      = emit;
    assign sts.norm_done = w_reg[36];
    assign sts.iter_done = (j_reg == 4'd15);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign norm_value    = norm_reg;
    assign channel_index = ch_reg;
    assign pixel_index   = px_reg;
    assign last          = last_reg;

endmodule

// File: verif/lrn_across_channels_tb.sv
// Self-checking testbench for the cross-channel local response normalizer.
`timescale 1ns / 100ps

module lrn_across_channels_tb;

    // Input commands.
    localparam bit CMD_VALUE = 1'b0;
    localparam bit CMD_FLUSH = 1'b1;

    localparam int PIX_DEPTH  = 4096;
    localparam int WIN_DEPTH  = 9;
    localparam int CHAN_DEPTH = 1024;
    localparam logic [63:0] SUM_CEIL = (64'd1 << 36) - 64'd1;

    // Settle long enough for the block to finish any beat in flight.
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_BEATS  = 1600;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic signed [15:0] sample_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] norm_value;
    logic [9:0]         channel_index;
    logic [11:0]        pixel_index;
    logic               last;

    lrn_across_channels u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .norm_value    (norm_value),
        .channel_index (channel_index),
        .pixel_index   (pixel_index),
        .last          (last)
    );

    // One normalized output beat.
    typedef struct {
        logic signed [15:0] norm;
        logic [9:0]         chan;
        logic [11:0]        pix;
        logic               last;
    } norm_beat_t;

    // A row of the directed table. Rows with load set first reprogram all
    // registers; rows with typed set carry a hand-computed normalized value.
    typedef struct packed {
        logic        load;
        logic [10:0] chans;
        logic [12:0] pixels;
        logic [3:0]  win;
        logic [31:0] alpha;
        logic [15:0] beta;
        logic        cmd;
        logic [15:0] val;
        logic        typed;
        logic [15:0] want;
    } dir_row_t;

    localparam int DIR_ROWS = 14;
    // First group: alpha of zero makes the output equal to the centered input,
    // so the extremes come straight back. Second group: the largest alpha and
    // beta shift the result to zero, with an activation past the real channels
    // that must read as zero. Third group: beta of zero passes values through,
    // and a flush among the real channels reads as a zero activation.
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{1'b1, 11'd2, 13'd2, 4'd3, 32'd0, 16'd3072, CMD_VALUE, 16'h7FFF, 1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'h8000, 1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'h0001, 1'b1, 16'h7FFF},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'hFFFF, 1'b1, 16'h8000},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_FLUSH, 16'h5555, 1'b1, 16'h0001},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_FLUSH, 16'h0000, 1'b1, 16'hFFFF},
        '{1'b1, 11'd1, 13'd1, 4'd9, 32'hFFFFFFFF, 16'hFFFF, CMD_VALUE, 16'h8000,
          1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'h3039, 1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_FLUSH, 16'h0000, 1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_FLUSH, 16'hAAAA, 1'b0, 16'h0},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'hFFFF, 1'b1, 16'h0000},
        '{1'b1, 11'd3, 13'd1, 4'd1, 32'hFFFFFFFF, 16'd0, CMD_FLUSH, 16'h1234,
          1'b1, 16'h0000},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'h0064, 1'b1, 16'h0064},
        '{1'b0, 11'd0, 13'd0, 4'd0, 32'd0, 16'd0, CMD_VALUE, 16'hFF9C, 1'b1, 16'hFF9C}
    };

    // Shadow copy of the registers as the block should see them.
    logic [10:0] shadow_chans;
    logic [12:0] shadow_pixels;
    logic [3:0]  shadow_win;
    logic [31:0] shadow_alpha;
    logic [15:0] shadow_beta;

    // Shadow copy of the datapath state.
    logic [35:0] sq_sum_mem [0:PIX_DEPTH-1];
    logic [15:0] history_mem [0:PIX_DEPTH*WIN_DEPTH-1];
    int unsigned pos_chan;
    int unsigned pos_pix;
    logic [63:0] exp2_tab [1:16];

    norm_beat_t pending_q [$];
    int         error_count;
    int         random_beats;
    bit         rx_hold_req;

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    // Hard limit on run time, far above the slowest legal run.
    initial
    begin
        #80_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Integer square root by setting one result bit at a time, top down.
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // log2 of a Q16.16 value of at least one, as a Q.16 result.
    function automatic logic [63:0] log2_fix(input logic [63:0] u);
        int          k;
        logic [63:0] m;
        logic [63:0] res;
        k = 16;
        while (k < 63 && (u >> (k + 1)) != 64'd0)
            k++;
        m   = (k > 31) ? (u >> (k - 31)) : (u << (31 - k));
        res = 64'(k - 16) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // Scales one activation by (1 + alpha*sum)^-beta and saturates to Q8.8.
    function automatic logic signed [15:0] scale_act(input int x, input logic [63:0] sum);
        logic [63:0] scaled;
        logic [63:0] e;
        logic [63:0] n;
        logic [15:0] f;
        logic [63:0] g;
        logic [63:0] mag;
        logic [63:0] r;
        int          s;
        scaled = 64'(shadow_alpha) * (sum >> 32)
               + ((64'(shadow_alpha) * (sum & 64'hFFFF_FFFF)) >> 32);
        e = 64'(shadow_beta) * log2_fix(64'd65536 + scaled);
        n = e >> 28;
        f = e[27:12];
        g = 64'd1 << 31;
        for (int i = 1; i <= 16; i++)
            if (f[16 - i])
                g = (g * exp2_tab[i]) >> 31;
        mag = 64'(x < 0 ? -x : x) * g;
        if (n + 64'd31 >= 64'd63)
            return 16'sd0;
        s = int'(n) + 31;
        r = (mag + (64'd1 << (s - 1))) >> s;
        if (x < 0)
            return (r > 64'd32768) ? -16'sd32768 : 16'(-int'(r));
        return (r > 64'd32767) ? 16'sd32767 : 16'(int'(r));
    endfunction

    // Advances the shadow state by one accepted beat; returns 1 with the
    // expected output when the beat releases a normalized value.
    function automatic bit predict_norm(input logic cmd, input logic signed [15:0] val,
                                        output norm_beat_t res);
        int unsigned cc;
        int unsigned pc;
        int unsigned ws;
        int unsigned h;
        int unsigned total;
        int unsigned c;
        int unsigned p;
        int unsigned oc;
        int          x;
        int          old;
        logic [63:0] sq;
        logic [63:0] sum;
        logic [63:0] osq;
        bit          fired;
        cc = shadow_chans;
        pc = shadow_pixels;
        ws = shadow_win;
        if (cc < 1) cc = 1;
        if (cc > CHAN_DEPTH) cc = CHAN_DEPTH;
        if (pc < 1) pc = 1;
        if (pc > PIX_DEPTH) pc = PIX_DEPTH;
        if (ws < 1) ws = 1;
        if (ws > WIN_DEPTH) ws = WIN_DEPTH;
        h     = ws / 2;
        total = cc + h;
        c     = pos_chan;
        p     = pos_pix;
        fired = 1'b0;
        res   = '{norm: '0, chan: '0, pix: '0, last: 1'b0};
        if (p >= PIX_DEPTH) p = 0;

        x   = (cmd == CMD_VALUE && c < cc) ? int'(val) : 0;
        old = int'($signed(history_mem[(c % ws) * PIX_DEPTH + p]));
        sq  = 64'(longint'(x) * longint'(x));
        sum = (c == 0) ? sq : 64'(sq_sum_mem[p]) + sq;
        if (sum > SUM_CEIL) sum = SUM_CEIL;
        if (c >= ws)
        begin
            osq = 64'(longint'(old) * longint'(old));
            sum = (sum > osq) ? sum - osq : 64'd0;
        end
        sq_sum_mem[p] = sum[35:0];
        history_mem[(c % ws) * PIX_DEPTH + p] = 16'(x);

        if (c >= h)
        begin
            oc        = c - h;
            res.norm  = scale_act(int'($signed(history_mem[(oc % ws) * PIX_DEPTH + p])), sum);
            res.chan  = 10'(oc);
            res.pix   = 12'(p);
            res.last  = (p + 1 >= pc && c + 1 >= total);
            fired     = 1'b1;
        end

        if (p + 1 >= pc)
        begin
            p = 0;
            c = (c + 1 >= total) ? 0 : c + 1;
        end
        else
        begin
            p++;
        end
        pos_pix  = p;
        pos_chan = c;
        return fired;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Output checker: every accepted output beat is matched with the oldest
    // expectation. Outputs are stable here because they only change on the
    // block's own clock edge, after this sample is taken.
    always @(posedge clk)
    begin
        norm_beat_t wanted;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected output beat, channel", channel_index, -1);
            end
            else
            begin
                wanted = pending_q.pop_front();
                if (norm_value !== wanted.norm)
                    report_mismatch("norm_value", norm_value, wanted.norm);
                if (channel_index !== wanted.chan)
                    report_mismatch("channel_index", channel_index, wanted.chan);
                if (pixel_index !== wanted.pix)
                    report_mismatch("pixel_index", pixel_index, wanted.pix);
                if (last !== wanted.last)
                    report_mismatch("last", last, wanted.last);
            end
        end
    end

    // Receiver. It mixes short stalls, long stalls and runs with ready held
    // high. When the stimulus asks for a hold-off, ready stays low for a
    // counted stretch so the block backs up and stalls its input.
    initial
    begin
        int hold_count;
        int pick;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready = 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                begin
                    out_ready = 1'b0;
                    repeat ($urandom_range(20, 90)) @(negedge clk);
                end
                else if (pick < 4)
                begin
                    out_ready = 1'b1;
                    repeat ($urandom_range(50, 200)) @(negedge clk);
                end
                else
                begin
                    out_ready = 1'b1;
                    repeat ($urandom_range(1, 8)) @(negedge clk);
                    out_ready = 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                end
            end
        end
    end

    // Register write: setup cycle, then access cycle. The shadow copy is
    // updated at the edge where the block takes the write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            lac_pkg::REG_CHANNEL_COUNT:   shadow_chans  = data[10:0];
            lac_pkg::REG_PIXEL_COUNT:     shadow_pixels = data[12:0];
            lac_pkg::REG_WINDOW_SIZE:     shadow_win    = data[3:0];
            lac_pkg::REG_ALPHA_OVER_SIZE: shadow_alpha  = data;
            lac_pkg::REG_BETA_EXPONENT:   shadow_beta   = data[15:0];
            default:                      ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Waits until every expected beat has come out and the block has had
    // time to finish any beat that yields nothing. Leaves in_valid low.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_all(input logic [10:0] cc, input logic [12:0] pc,
                               input logic [3:0] ws, input logic [31:0] a,
                               input logic [15:0] b);
        wait_idle();
        write_reg(lac_pkg::REG_CHANNEL_COUNT, 32'(cc));
        write_reg(lac_pkg::REG_PIXEL_COUNT, 32'(pc));
        write_reg(lac_pkg::REG_WINDOW_SIZE, 32'(ws));
        write_reg(lac_pkg::REG_ALPHA_OVER_SIZE, a);
        write_reg(lac_pkg::REG_BETA_EXPONENT, 32'(b));
    endtask

    // Offers one input beat, called and returning at a falling edge. Valid
    // is left high so back-to-back beats never drop it within one step.
    task automatic send_beat(input logic cmd, input logic [15:0] val, input bit gaps,
                             input bit typed, input logic [15:0] want);
        int         gap;
        int         pick;
        norm_beat_t res;
        gap = 0;
        if (gaps)
        begin
            pick = $urandom_range(0, 31);
            if (pick >= 30)
                gap = $urandom_range(15, 60);
            else if (pick >= 22)
                gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        command      = cmd;
        sample_value = val;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_norm(cmd, val, res))
        begin
            if (typed)
                res.norm = want;
            pending_q.push_back(res);
        end
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return 32'($urandom_range(0, 100000));
            4:       return 32'd85899;
            default: return $urandom >> $urandom_range(4, 24);
        endcase
    endfunction

    function automatic logic [15:0] pick_beta();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            3:       return 16'd3072;
            default: return 16'($urandom_range(0, 8191));
        endcase
    endfunction

    // Sends one whole sample with the current register values: the real
    // channels, mostly activations with the odd flush, then the drain
    // channels, mostly flushes with the odd stray activation.
    task automatic send_sample(input bit gaps, input bit hold);
        int unsigned cc;
        int unsigned pc;
        int unsigned ws;
        logic        cmd;
        cc = (shadow_chans == 0) ? 1 : (shadow_chans > CHAN_DEPTH ? CHAN_DEPTH : shadow_chans);
        pc = (shadow_pixels == 0) ? 1 :
             (shadow_pixels > PIX_DEPTH ? PIX_DEPTH : shadow_pixels);
        ws = (shadow_win == 0) ? 1 : (shadow_win > WIN_DEPTH ? WIN_DEPTH : shadow_win);
        for (int unsigned c = 0; c < cc + ws / 2; c++)
        begin
            for (int unsigned p = 0; p < pc; p++)
            begin
                if (hold && c == 1 && p == 0)
                    rx_hold_req = 1'b1;
                if (c < cc)
                    cmd = ($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_VALUE;
                else
                    cmd = ($urandom_range(0, 9) == 0) ? CMD_VALUE : CMD_FLUSH;
                send_beat(cmd, pick_value(), gaps, 1'b0, 16'h0);
                random_beats++;
            end
        end
    endtask

    // Main stimulus.
    initial
    begin
        int sample_no;
        error_count  = 0;
        random_beats = 0;
        rx_hold_req  = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        command      = CMD_VALUE;
        sample_value = '0;

        shadow_chans  = 11'd64;
        shadow_pixels = 13'd1024;
        shadow_win    = 4'd5;
        shadow_alpha  = 32'd85899;
        shadow_beta   = 16'd3072;
        pos_chan      = 0;
        pos_pix       = 0;
        for (int i = 0; i < PIX_DEPTH; i++)
            sq_sum_mem[i] = '0;
        for (int i = 0; i < PIX_DEPTH * WIN_DEPTH; i++)
            history_mem[i] = '0;
        exp2_tab[1] = int_root(64'd1 << 61);
        for (int i = 2; i <= 16; i++)
            exp2_tab[i] = int_root(exp2_tab[i - 1] << 31);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table. Register rows start from an idle block.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TAB[r].load)
                program_all(DIR_TAB[r].chans, DIR_TAB[r].pixels, DIR_TAB[r].win,
                            DIR_TAB[r].alpha, DIR_TAB[r].beta);
            send_beat(DIR_TAB[r].cmd, DIR_TAB[r].val, 1'b0, DIR_TAB[r].typed,
                      DIR_TAB[r].want);
        end

        // Random samples, each with fresh registers. Samples end with the
        // positions back at zero, so no stale history entry is ever read.
        sample_no    = 0;
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            case (sample_no)
                // Filled sample for the receiver hold-off.
                2:  program_all(11'd8, 13'd4, 4'd3, pick_alpha(), pick_beta());
                // Widest channel count (clamped) with the widest window code.
                5:  program_all(11'd2047, 13'd1, 4'd15, pick_alpha(), pick_beta());
                // Zero codes for channels, pixels and window, each taken as one.
                9:  program_all(11'd0, 13'd0, 4'd0, pick_alpha(), pick_beta());
                default:
                    program_all(11'($urandom_range(1, 6)), 13'($urandom_range(1, 6)),
                                4'($urandom_range(0, 15)), pick_alpha(), pick_beta());
            endcase
            send_sample((sample_no % 4) != 3, sample_no == 2);
            sample_no++;
        end

        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
